### hw/rtl/sle_pkg.sv
// Shared types, character codes and the command word tables of the serial
// line editor and command matcher.
// Used by sle_line_tracker and serial_line_editor_command_matcher_core.
package sle_pkg;

	// Default line buffer depth; a line holds one character less.
	localparam int LINE_DEPTH_DEF = 64;

	// Command table geometry: five words, each at most seven characters.
	localparam int CMD_COUNT = 5;
	localparam int CMD_SLOTS = 8;
	localparam int SLOT_W    = $clog2(CMD_SLOTS);

	// Character codes.
	localparam logic [7:0] CH_BELL     = 8'h07;
	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SP       = 8'h20;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_PRINT_HI = 8'h7E;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_NUL      = 8'h00;

	// Color intensities.
	localparam logic [7:0] LVL_FULL = 8'hFF;
	localparam logic [7:0] LVL_OFF  = 8'h00;

	// Command identifiers, in table order.
	typedef enum logic [2:0] {
		CMD_ALL_ON,
		CMD_ALL_OFF,
		CMD_RED,
		CMD_GRN,
		CMD_BLU
	} cmd_id_t;

	// Command words, padded with NUL.
	localparam logic [7:0] CMD_WORD [CMD_COUNT][CMD_SLOTS] = '{
		'{"L", "E", "D", "_", "O", "N", CH_NUL, CH_NUL},
		'{"L", "E", "D", "_", "O", "F", "F", CH_NUL},
		'{"R", "E", "D", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"G", "R", "E", "E", "N", CH_NUL, CH_NUL, CH_NUL},
		'{"B", "L", "U", "E", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
	};
	localparam logic [2:0] CMD_LEN [CMD_COUNT] = '{3'd6, 3'd7, 3'd3, 3'd5, 3'd4};

	// Colors set by each command.
	localparam logic [7:0] CMD_RED_LVL [CMD_COUNT] =
		'{LVL_FULL, LVL_OFF, LVL_FULL, LVL_OFF, LVL_OFF};
	localparam logic [7:0] CMD_GREEN_LVL [CMD_COUNT] =
		'{LVL_FULL, LVL_OFF, LVL_OFF, LVL_FULL, LVL_OFF};
	localparam logic [7:0] CMD_BLUE_LVL [CMD_COUNT] =
		'{LVL_FULL, LVL_OFF, LVL_OFF, LVL_OFF, LVL_FULL};

	// Kind of result sequence held in the output stage.
	typedef enum logic [1:0] {
		RES_ECHO,
		RES_BELL,
		RES_ERASE,
		RES_NEWLINE
	} res_kind_t;

	// Operation applied to the line state.
	typedef enum logic [1:0] {
		LOP_NONE,
		LOP_APPEND,
		LOP_ERASE,
		LOP_CLEAR
	} line_op_t;

	typedef struct packed {
		line_op_t   op;
		logic [7:0] ch;
	} line_upd_t;

	typedef struct packed {
		logic    empty;
		logic    full;
		logic    hit;
		cmd_id_t cmd;
	} line_stat_t;

endpackage

### hw/rtl/serial_line_editor_command_matcher_core.sv
// Serial line editor and command matcher, top level.
// Inputs pass the input stage, then the output stage. Throughput: one input per
// cycle for inputs with zero or one result while out_ready is high; an erase
// gives three results and an end of line two, one per cycle from the single
// output register. Reset clears the line length and the valid flags of both
// stages; the per-position match flags are not reset.
module serial_line_editor_command_matcher_core #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_valid,
	output logic [7:0] tx_byte,
	output logic       led_update,
	output logic [7:0] led_red,
	output logic [7:0] led_green,
	output logic [7:0] led_blue,
	output logic       unknown_command,
	output logic       line_overflow,
	output logic       last
);
	import sle_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic       op_s1;
	logic [7:0] byte_s1;

	// Output stage.
	logic       valid_s2;
	res_kind_t  kind_s2;
	logic [7:0] byte_s2;
	logic       hit_s2;
	logic       unk_s2;
	cmd_id_t    cmd_s2;
	logic [1:0] idx_s2;

	line_upd_t  upd;
	line_stat_t stat;

	logic       is_eol;
	logic       is_erase;
	logic       is_print;
	logic       no_result;
	logic       s2_room;
	logic       s1_fire;
	logic       in_xfer;
	res_kind_t  kind_d;

	sle_line_tracker #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.stat   (stat)
	);

	// Classify the byte held in the input stage.
	assign is_eol    = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign is_erase  = (byte_s1 == CH_BS) || (byte_s1 == CH_DEL);
	assign is_print  = (byte_s1 >= CH_PRINT_LO) && (byte_s1 <= CH_PRINT_HI);
	assign no_result = op_s1 || (is_erase && stat.empty) ||
		!(is_eol || is_erase || is_print);

	// The input stage moves on when its item needs no result or the output
	// stage is free or sends its final result this cycle.
	assign s2_room  = !valid_s2 || (out_ready && last);
	assign s1_fire  = valid_s1 && (no_result || s2_room);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_xfer  = in_valid && in_ready;

	// Line state update and result kind for the item leaving the input stage.
	always_comb begin
		upd.ch = byte_s1;
		upd.op = LOP_NONE;
		if (is_eol) begin
			kind_d = RES_NEWLINE;
		end else if (is_erase) begin
			kind_d = RES_ERASE;
		end else if (stat.full) begin
			kind_d = RES_BELL;
		end else begin
			kind_d = RES_ECHO;
		end
		if (s1_fire) begin
			if (op_s1 || is_eol) begin
				upd.op = LOP_CLEAR;
			end else if (is_erase && !stat.empty) begin
				upd.op = LOP_ERASE;
			end else if (is_print && !stat.full) begin
				upd.op = LOP_APPEND;
			end
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	// Output stage control: load a result sequence, then step through it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (s1_fire && !no_result) begin
			valid_s2 <= 1'b1;
			idx_s2   <= '0;
		end else if (valid_s2 && out_ready) begin
			if (last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	// Output stage payload.
	always_ff @(posedge clk) begin
		if (s1_fire && !no_result) begin
			kind_s2 <= kind_d;
			byte_s2 <= byte_s1;
			hit_s2  <= is_eol && !stat.empty && stat.hit;
			unk_s2  <= is_eol && !stat.empty && !stat.hit;
			cmd_s2  <= stat.cmd;
		end
	end

	// Result fields from the output stage.
	always_comb begin
		case (kind_s2)
			RES_ECHO: begin
				tx_byte = byte_s2;
				last    = 1'b1;
			end
			RES_BELL: begin
				tx_byte = CH_BELL;
				last    = 1'b1;
			end
			RES_ERASE: begin
				tx_byte = (idx_s2 == 2'd1) ? CH_SP : CH_BS;
				last    = (idx_s2 == 2'd2);
			end
			default: begin
				tx_byte = (idx_s2 == 2'd0) ? CH_CR : CH_LF;
				last    = (idx_s2 == 2'd1);
			end
		endcase
	end

	assign out_valid       = valid_s2;
	assign tx_valid        = 1'b1;
	assign line_overflow   = (kind_s2 == RES_BELL);
	assign led_update      = hit_s2 && last;
	assign unknown_command = unk_s2 && last;
	assign led_red         = led_update ? CMD_RED_LVL[cmd_s2] : LVL_OFF;
	assign led_green       = led_update ? CMD_GREEN_LVL[cmd_s2] : LVL_OFF;
	assign led_blue        = led_update ? CMD_BLUE_LVL[cmd_s2] : LVL_OFF;

`ifndef ASSERT_OFF
	a_update_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_update |-> last && (kind_s2 == RES_NEWLINE))
		else $error("color update outside the final newline result");
	a_update_xor_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(led_update && unknown_command))
		else $error("command both matched and unknown");
	a_sequence_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && (idx_s2 == $past(idx_s2) + 2'd1))
		else $error("result sequence cut short");
`endif

endmodule

### hw/rtl/sle_line_tracker.sv
// Line length counter and per-position command match flags.
// Depends on sle_pkg for the command tables and the update/status structs.
module sle_line_tracker #(
	parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sle_pkg::line_upd_t  upd,
	output sle_pkg::line_stat_t stat
);
	import sle_pkg::*;

	localparam int             LEN_W   = $clog2(LINE_DEPTH);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);

	logic [LEN_W-1:0]         length_q;
	logic [CMD_COUNT-1:0]     eq_q [CMD_SLOTS];
	logic [SLOT_W-1:0]        slot;
	logic                     in_window;
	logic [LEN_W+SLOT_W-1:0]  len_wide;
	logic [CMD_COUNT-1:0]     hit_vec;

	// Position of the next character and whether it falls inside the match window.
	assign slot      = length_q[SLOT_W-1:0];
	assign len_wide  = {{SLOT_W{1'b0}}, length_q};
	assign in_window = (len_wide >> SLOT_W) == '0;

	// Line length counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else begin
			case (upd.op)
				LOP_APPEND: length_q <= length_q + 1'b1;
				LOP_ERASE:  length_q <= length_q - 1'b1;
				LOP_CLEAR:  length_q <= '0;
				default:    length_q <= length_q;
			endcase
		end
	end

	// Each stored position keeps one flag per command: the character there
	// equals that command's character at the same position.
	always_ff @(posedge clk) begin
		if (upd.op == LOP_APPEND && in_window) begin
			for (int c = 0; c < CMD_COUNT; c++) begin
				eq_q[slot][c] <= (upd.ch == CMD_WORD[c][slot]);
			end
		end
	end

	// A command matches when the length equals its word length and every
	// position below that length agrees.
	always_comb begin
		logic all_eq;
		for (int c = 0; c < CMD_COUNT; c++) begin
			all_eq = 1'b1;
			for (int p = 0; p < CMD_SLOTS; p++) begin
				if (p < int'(CMD_LEN[c])) begin
					all_eq = all_eq & eq_q[p][c];
				end
			end
			hit_vec[c] = all_eq && (length_q == LEN_W'(CMD_LEN[c]));
		end
	end

	// Status toward the decoder.
	always_comb begin
		stat.empty = (length_q == '0);
		stat.full  = (length_q == LEN_MAX);
		stat.hit   = |hit_vec;
		stat.cmd   = CMD_ALL_ON;
		for (int c = CMD_COUNT - 1; c >= 0; c--) begin
			if (hit_vec[c]) begin
				stat.cmd = cmd_id_t'(3'(c));
			end
		end
	end

`ifndef ASSERT_OFF
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_MAX)
		else $error("line length beyond the buffer");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		upd.op == LOP_CLEAR |=> stat.empty)
		else $error("line not empty after clear");
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		upd.op == LOP_APPEND |-> !stat.full)
		else $error("append requested on a full line");
`endif

endmodule

### sim/serial_line_editor_command_matcher_core_test.sv
// Self-checking testbench for serial_line_editor_command_matcher_core: drives
// received bytes and flushes, predicts echo, erase, bell and command results.
// Depends on sle_pkg and the core RTL only.
module serial_line_editor_command_matcher_core_test;
	import sle_pkg::*;

	localparam int LINE_DEPTH = LINE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 470;
	localparam int CYCLE_LIMIT = 600000;

	// Input operation codes.
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       led_update;
		logic [7:0] led_red;
		logic [7:0] led_green;
		logic [7:0] led_blue;
		logic       unknown_command;
		logic       line_overflow;
		logic       last;
	} echo_result_t;

	// Line editor state mirror and the queue of results still owed by the block.
	class line_echo_scoreboard;
		logic [7:0]   line_chars [LINE_DEPTH];
		int unsigned  line_len;
		echo_result_t awaited [$];
		int unsigned  mismatches;
		int unsigned  results_seen;

		function new();
			line_len = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function string command_word(cmd_id_t c);
			case (c)
				CMD_ALL_ON:  return "LED_ON";
				CMD_ALL_OFF: return "LED_OFF";
				CMD_RED:     return "RED";
				CMD_GRN:     return "GREEN";
				default:     return "BLUE";
			endcase
		endfunction

		// Color as {red, green, blue}.
		function logic [23:0] command_color(cmd_id_t c);
			case (c)
				CMD_ALL_ON:  return {LVL_FULL, LVL_FULL, LVL_FULL};
				CMD_ALL_OFF: return {LVL_OFF, LVL_OFF, LVL_OFF};
				CMD_RED:     return {LVL_FULL, LVL_OFF, LVL_OFF};
				CMD_GRN:     return {LVL_OFF, LVL_FULL, LVL_OFF};
				default:     return {LVL_OFF, LVL_OFF, LVL_FULL};
			endcase
		endfunction

		// Index of the command that the whole line spells, or -1.
		function int find_command();
			string w;
			bit same;
			for (int k = 0; k < CMD_COUNT; k++) begin
				w = command_word(cmd_id_t'(k));
				if (w.len() == line_len) begin
					same = 1'b1;
					for (int i = 0; i < w.len(); i++)
						if (line_chars[i] != w[i])
							same = 1'b0;
					if (same)
						return k;
				end
			end
			return -1;
		endfunction

		function echo_result_t tx_only(logic [7:0] b, logic fin);
			echo_result_t r;
			r = '0;
			r.tx_valid = 1'b1;
			r.tx_byte = b;
			r.last = fin;
			return r;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// Updates the line and queues what one input transfer owes.
		// Returns 0 when the item leaves the block untouched.
		function bit note_input(logic op, logic [7:0] ch);
			echo_result_t r;
			int hit;
			if (op == OP_FLUSH) begin
				line_len = 0;
				return 1'b1;
			end
			if (ch == CH_CR || ch == CH_LF) begin
				awaited.push_back(tx_only(CH_CR, 1'b0));
				r = tx_only(CH_LF, 1'b1);
				if (line_len != 0) begin
					hit = find_command();
					if (hit >= 0) begin
						r.led_update = 1'b1;
						{r.led_red, r.led_green, r.led_blue} = command_color(cmd_id_t'(hit));
					end else begin
						r.unknown_command = 1'b1;
					end
					line_len = 0;
				end
				awaited.push_back(r);
				return 1'b1;
			end
			if (ch == CH_BS || ch == CH_DEL) begin
				if (line_len == 0)
					return 1'b0;
				line_len--;
				awaited.push_back(tx_only(CH_BS, 1'b0));
				awaited.push_back(tx_only(CH_SP, 1'b0));
				awaited.push_back(tx_only(CH_BS, 1'b1));
				return 1'b1;
			end
			if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
				if (line_len < LINE_DEPTH - 1) begin
					line_chars[line_len] = ch;
					line_len++;
					awaited.push_back(tx_only(ch, 1'b1));
				end else begin
					r = tx_only(CH_BELL, 1'b1);
					r.line_overflow = 1'b1;
					awaited.push_back(r);
				end
				return 1'b1;
			end
			return 1'b0;
		endfunction

		task report(string what);
			$display("[%0t] mismatch on result %0d: %s", $realtime, results_seen, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("%s is %h, expected %h", name, got, want));
		endtask

		task compare_flag(string name, logic got, logic want);
			if (got !== want)
				report($sformatf("%s is %b, expected %b", name, got, want));
		endtask

		// Compares one output transfer with the oldest queued result.
		task check_result(echo_result_t got);
			echo_result_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result, tx_byte %h", got.tx_byte));
			end else begin
				want = awaited.pop_front();
				compare_flag("tx_valid", got.tx_valid, want.tx_valid);
				compare_field("tx_byte", got.tx_byte, want.tx_byte);
				compare_flag("led_update", got.led_update, want.led_update);
				compare_field("led_red", got.led_red, want.led_red);
				compare_field("led_green", got.led_green, want.led_green);
				compare_field("led_blue", got.led_blue, want.led_blue);
				compare_flag("unknown_command", got.unknown_command, want.unknown_command);
				compare_flag("line_overflow", got.line_overflow, want.line_overflow);
				compare_flag("last", got.last, want.last);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       operation = OP_BYTE;
	logic [7:0] rx_byte = CH_NUL;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       led_update;
	logic [7:0] led_red;
	logic [7:0] led_green;
	logic [7:0] led_blue;
	logic       unknown_command;
	logic       line_overflow;
	logic       last;

	line_echo_scoreboard sb = new();
	bit          steady = 1'b0;
	int          stall_left = 0;
	int unsigned items_counted = 0;
	int unsigned cycle_count = 0;

	serial_line_editor_command_matcher_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.operation       (operation),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_valid        (tx_valid),
		.tx_byte         (tx_byte),
		.led_update      (led_update),
		.led_red         (led_red),
		.led_green       (led_green),
		.led_blue        (led_blue),
		.unknown_command (unknown_command),
		.line_overflow   (line_overflow),
		.last            (last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Idle length: mostly none or short, a few long; none in steady stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver backpressure.
	always @(posedge clk) begin : ready_gen
		int stall_len;
		if (steady) begin
			out_ready <= 1'b1;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			stall_len = ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
			out_ready <= (stall_len == 0);
			stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
		end
	end

	// Every output transfer is checked against the predicted queue.
	always @(posedge clk) begin : result_monitor
		echo_result_t got;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got.tx_valid = tx_valid;
			got.tx_byte = tx_byte;
			got.led_update = led_update;
			got.led_red = led_red;
			got.led_green = led_green;
			got.led_blue = led_blue;
			got.unknown_command = unknown_command;
			got.line_overflow = line_overflow;
			got.last = last;
			sb.check_result(got);
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// One input transfer, after an optional idle gap.
	task automatic send_item(logic op, logic [7:0] ch);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= ch;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (sb.note_input(op, ch))
			items_counted++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_BYTE, s[i]);
	endtask

	// Hold the sender until the block has delivered everything owed.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] any_printable();
		return 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
	endfunction

	function automatic logic [7:0] any_erase();
		return $urandom_range(0, 1) ? CH_BS : CH_DEL;
	endfunction

	function automatic logic [7:0] any_eol();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	// A command word, possibly with a corrected typo or a near miss, then end of line.
	task automatic run_command_line(cmd_id_t c, bit mangle);
		string w;
		int slip;
		int pos;
		w = sb.command_word(c);
		if (mangle) begin
			pos = $urandom_range(0, w.len() - 1);
			case ($urandom_range(0, 2))
				0: w = w.substr(0, w.len() - 2);
				1: w = {w, string'(any_printable())};
				default: w[pos] = any_printable();
			endcase
		end
		slip = ($urandom_range(0, 2) == 0) ? $urandom_range(0, w.len() - 1) : -1;
		for (int i = 0; i < w.len(); i++) begin
			send_item(OP_BYTE, w[i]);
			if (i == slip) begin
				send_item(OP_BYTE, any_printable());
				send_item(OP_BYTE, any_erase());
			end
		end
		send_item(OP_BYTE, any_eol());
	endtask

	// Fills the line to its capacity and usually past it, so the bell and overflow flag show up.
	task automatic run_long_line();
		int n;
		n = $urandom_range(LINE_DEPTH - 1, LINE_DEPTH + 4);
		repeat (n) send_item(OP_BYTE, any_printable());
		if ($urandom_range(0, 3) == 0)
			send_item(OP_BYTE, any_erase());
		send_item(OP_BYTE, any_eol());
	endtask

	initial begin
		int unsigned start;
		int pick;
		int n;
		bit pressed;
		string w;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: flush, erase and end of line on an empty line, byte extremes,
		// one command, one unknown line and a flush with a partial line.
		send_item(OP_FLUSH, 8'hFF);
		send_item(OP_BYTE, CH_BS);
		send_item(OP_BYTE, CH_DEL);
		send_item(OP_BYTE, CH_CR);
		send_item(OP_BYTE, CH_LF);
		send_item(OP_BYTE, CH_NUL);
		send_item(OP_BYTE, 8'h1F);
		send_item(OP_BYTE, 8'h80);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, CH_PRINT_LO);
		send_item(OP_BYTE, CH_PRINT_HI);
		send_item(OP_BYTE, CH_DEL);
		send_item(OP_BYTE, CH_BS);
		send_text("RED");
		send_item(OP_BYTE, CH_CR);
		send_text("Q");
		send_item(OP_BYTE, CH_LF);
		send_text("AB");
		send_item(OP_FLUSH, CH_NUL);
		send_item(OP_BYTE, CH_CR);
		drain();

		// Random part: every command once and one long line first.
		start = items_counted;
		pressed = 1'b0;
		for (int k = 0; k < CMD_COUNT; k++)
			run_command_line(cmd_id_t'(k), 1'b0);
		run_long_line();

		while (items_counted - start < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				steady = !steady;
			if ((!pressed && items_counted - start >= RANDOM_ITEMS / 2)
					|| $urandom_range(0, 49) == 0) begin
				drain();
				pressed = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				run_command_line(cmd_id_t'($urandom_range(0, CMD_COUNT - 1)),
					$urandom_range(0, 4) == 0);
			end else if (pick < 60) begin
				// Free text with stray erases.
				n = $urandom_range(0, 12);
				repeat (n)
					send_item(OP_BYTE, ($urandom_range(0, 4) == 0) ? any_erase()
						: any_printable());
				send_item(OP_BYTE, any_eol());
			end else if (pick < 63) begin
				run_long_line();
			end else if (pick < 73) begin
				// Partial line dropped by a flush.
				n = $urandom_range(0, 8);
				repeat (n) send_item(OP_BYTE, any_printable());
				send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
			end else if (pick < 88) begin
				// Noise over the full byte range, flushes now and then.
				n = $urandom_range(1, 6);
				repeat (n)
					send_item(($urandom_range(0, 7) == 0) ? OP_FLUSH : OP_BYTE,
						8'($urandom_range(0, 255)));
			end else begin
				// Abandoned command, erased back to the start or past it, then a clean one.
				w = sb.command_word(cmd_id_t'($urandom_range(0, CMD_COUNT - 1)));
				n = $urandom_range(1, w.len());
				for (int i = 0; i < n; i++)
					send_item(OP_BYTE, w[i]);
				repeat (n + $urandom_range(0, 2)) send_item(OP_BYTE, any_erase());
				run_command_line(cmd_id_t'($urandom_range(0, CMD_COUNT - 1)), 1'b0);
			end
		end

		// Let the last results out, then allow for stragglers.
		steady = 1'b0;
		drain();
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### serial_line_editor_command_matcher_core.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_line_tracker.sv
hw/rtl/serial_line_editor_command_matcher_core.sv
sim/serial_line_editor_command_matcher_core_test.sv
